// ===== src/art_pkg.sv =====
// ----------------------------------------------------------------------------
// art_pkg
// shared sizes, request codes and status codes of the access rights table
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 64;
  localparam int RIGHTS_BITS = 32;

  localparam int ADDR_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int ENTRY_W = KEY_BITS + 2 * RIGHTS_BITS;

  typedef enum logic [1:0] {
    OP_GRANT  = 2'd0,
    OP_DENY   = 2'd1,
    OP_REVOKE = 2'd2,
    OP_CHECK  = 2'd3
  } req_op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } req_status_t;

endpackage

// ===== src/art_ram.sv =====
// ----------------------------------------------------------------------------
// art_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/access_rights_table.sv =====
// ----------------------------------------------------------------------------
// access_rights_table
// principal table with allow / deny masks, scanned from a single ram
// ----------------------------------------------------------------------------
// a request passes through the scan and update steps; the scan covers the entries in use
// and reads one ram entry per cycle, ending early at a hit
// one request at a time, taken only while idle; start may be taken in the done cycle
// the receiver cannot stall: each result word is shown for one cycle only
// reset clears the fill count and the sequencer; ram contents are not cleared
// entries at or above the fill count are never matched on a read
// ----------------------------------------------------------------------------
module access_rights_table
  import art_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  req_type,
  input  logic [63:0] principal_key,
  input  logic [31:0] rights_mask,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status,
  output logic        permitted
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_t;

  state_t                 state;
  req_op_t                op_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [RIGHTS_BITS-1:0] rights_q;
  logic [CNT_W-1:0]       scan_idx;
  logic [ADDR_W-1:0]      cmp_idx;
  logic                   rd_vld;
  logic                   found;
  logic [ADDR_W-1:0]      hit_idx;
  logic [RIGHTS_BITS-1:0] hit_allow;
  logic [RIGHTS_BITS-1:0] hit_deny;
  logic [CNT_W-1:0]       used;

  logic                   we;
  logic [ADDR_W-1:0]      wr_addr;
  logic [ENTRY_W-1:0]     wr_data;
  logic [ENTRY_W-1:0]     rd_data;
  logic [KEY_BITS-1:0]    rd_key;
  logic [RIGHTS_BITS-1:0] rd_allow;
  logic [RIGHTS_BITS-1:0] rd_deny;

  req_status_t            upd_status;
  logic                   upd_permitted;
  logic                   upd_append;
  logic                   table_full;

  // entry layout: key | allow | deny
  assign rd_key   = rd_data[ENTRY_W-1 -: KEY_BITS];
  assign rd_allow = rd_data[2*RIGHTS_BITS-1 -: RIGHTS_BITS];
  assign rd_deny  = rd_data[RIGHTS_BITS-1:0];

  assign table_full = (used == CNT_W'(MAX_ENTRIES));
  assign busy       = (state != S_IDLE);

  art_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (scan_idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // update step: read-modify-write of the hit entry, append of a new one, or the check result
  always_comb begin
    we            = 1'b0;
    wr_addr       = hit_idx;
    wr_data       = {key_q, hit_allow, hit_deny};
    upd_status    = ST_DONE;
    upd_permitted = 1'b0;
    upd_append    = 1'b0;
    if (state == S_UPDATE) begin
      case (op_q)
        OP_GRANT: begin
          if (found) begin
            we      = 1'b1;
            wr_data = {key_q, hit_allow | rights_q, hit_deny};
          end else if (!table_full) begin
            we         = 1'b1;
            upd_append = 1'b1;
            wr_addr    = used[ADDR_W-1:0];
            wr_data    = {key_q, rights_q, {RIGHTS_BITS{1'b0}}};
          end else begin
            upd_status = ST_FULL;
          end
        end
        OP_DENY: begin
          if (found) begin
            we      = 1'b1;
            wr_data = {key_q, hit_allow, hit_deny | rights_q};
          end else begin
            upd_status = ST_NOT_FOUND;
          end
        end
        OP_REVOKE: begin
          if (found) begin
            we      = 1'b1;
            wr_data = {key_q, hit_allow & ~rights_q, hit_deny};
          end else begin
            upd_status = ST_NOT_FOUND;
          end
        end
        default: begin
          if (found) begin
            upd_permitted = ((hit_allow & rights_q) == rights_q) &&
                            ((hit_deny & rights_q) == '0);
          end else begin
            upd_status = ST_NOT_FOUND;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      done      <= 1'b0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      scan_idx  <= '0;
      status    <= ST_DONE;
      permitted <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q     <= req_op_t'(req_type);
            key_q    <= principal_key[KEY_BITS-1:0];
            rights_q <= rights_mask[RIGHTS_BITS-1:0];
            scan_idx <= '0;
            rd_vld   <= 1'b0;
            found    <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read data belongs to the address issued in the previous cycle
          if (rd_vld && rd_key == key_q) begin
            found     <= 1'b1;
            hit_idx   <= cmp_idx;
            hit_allow <= rd_allow;
            hit_deny  <= rd_deny;
            rd_vld    <= 1'b0;
            state     <= S_UPDATE;
          end else if (scan_idx < used) begin
            cmp_idx  <= scan_idx[ADDR_W-1:0];
            scan_idx <= scan_idx + CNT_W'(1);
            rd_vld   <= 1'b1;
          end else begin
            rd_vld <= 1'b0;
            state  <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (upd_append) begin
            used <= used + CNT_W'(1);
          end
          status    <= upd_status;
          permitted <= upd_permitted;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_UPDATE))
    else $error("result word without an update step");

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(MAX_ENTRIES))
    else $error("fill count beyond table depth");

  a_full_only_grant: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (op_q == OP_GRANT && table_full))
    else $error("table full reported outside a grant on a full table");

  a_permit_only_check: assert property (@(posedge clk) disable iff (rst)
    (done && permitted) |-> (op_q == OP_CHECK && status == ST_DONE))
    else $error("permitted set outside a successful check");

  a_write_only_update: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_UPDATE && $past(state == S_SCAN)))
    else $error("ram write outside the update step");

endmodule

// ===== bench/access_rights_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// access_rights_table_tb
// fills the principal table with directed grants, hits each request and
// status code, then sends random requests against mostly known principals;
// every result word is checked against its directed row or a behavioral copy of the table
// ----------------------------------------------------------------------------
module access_rights_table_tb;
  import art_pkg::*;

  localparam int          CLK_HALF     = 2;
  localparam int          RESET_CYCLES = 7;
  localparam int          N_RANDOM     = 1500;
  localparam int          DRAIN_CYCLES = MAX_ENTRIES + 8;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam logic [63:0] KEY_KEEP     = {64{1'b1}} >> (64 - KEY_BITS);
  localparam logic [31:0] RIGHTS_KEEP  = {32{1'b1}} >> (32 - RIGHTS_BITS);

  typedef struct packed {
    req_status_t status;
    logic        permitted;
  } rights_result_t;

  typedef struct packed {
    req_op_t     op;
    logic [63:0] key;
    logic [31:0] mask;
    logic        known;
    req_status_t status;
    logic        permitted;
  } stim_row_t;

  localparam int N_DIRECTED = 31;

  // rows with known set carry their result; the others go through the predictor
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_CHECK,  64'h0,                   32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 1'b0},
    '{OP_DENY,   64'h0,                   32'h0000_0001, 1'b1, ST_NOT_FOUND, 1'b0},
    '{OP_REVOKE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 1'b0},
    '{OP_GRANT,  64'h0,                   32'hFFFF_FFFF, 1'b1, ST_DONE,      1'b0},
    '{OP_GRANT,  64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b1, ST_DONE,      1'b0},
    '{OP_CHECK,  64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b1, ST_DONE,      1'b1},
    '{OP_CHECK,  64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0001, 1'b1, ST_DONE,      1'b0},
    '{OP_CHECK,  64'h0,                   32'hFFFF_FFFF, 1'b1, ST_DONE,      1'b1},
    '{OP_DENY,   64'h0,                   32'h8000_0000, 1'b1, ST_DONE,      1'b0},
    '{OP_CHECK,  64'h0,                   32'h8000_0000, 1'b1, ST_DONE,      1'b0},
    '{OP_CHECK,  64'h0,                   32'h7FFF_FFFF, 1'b0, ST_DONE,      1'b0},
    '{OP_REVOKE, 64'h0,                   32'h0000_FFFF, 1'b1, ST_DONE,      1'b0},
    '{OP_CHECK,  64'h0,                   32'h0001_0001, 1'b0, ST_DONE,      1'b0},
    '{OP_GRANT,  64'h8000_0000_0000_0000, 32'h0000_0001, 1'b1, ST_DONE,      1'b0},
    '{OP_GRANT,  64'h0000_0000_0000_0001, 32'h8000_0000, 1'b1, ST_DONE,      1'b0},
    '{OP_GRANT,  64'h0123_4567_89AB_CDEF, 32'h1234_5678, 1'b1, ST_DONE,      1'b0},
    '{OP_GRANT,  64'hFEDC_BA98_7654_3210, 32'hEDCB_A987, 1'b1, ST_DONE,      1'b0},
    '{OP_GRANT,  64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 1'b1, ST_DONE,      1'b0},
    '{OP_GRANT,  64'h5555_5555_5555_5555, 32'h5555_5555, 1'b1, ST_DONE,      1'b0},
    '{OP_GRANT,  64'hFFFF_FFFF_FFFF_FFFE, 32'hFFFF_0000, 1'b1, ST_DONE,      1'b0},
    '{OP_GRANT,  64'h7FFF_FFFF_FFFF_FFFF, 32'h0000_FFFF, 1'b1, ST_DONE,      1'b0},
    '{OP_GRANT,  64'h0000_0000_FFFF_FFFF, 32'h0F0F_0F0F, 1'b1, ST_DONE,      1'b0},
    '{OP_GRANT,  64'hFFFF_FFFF_0000_0000, 32'hF0F0_F0F0, 1'b1, ST_DONE,      1'b0},
    '{OP_GRANT,  64'h0F0F_0F0F_0F0F_0F0F, 32'h0000_0000, 1'b1, ST_DONE,      1'b0},
    '{OP_GRANT,  64'hF0F0_F0F0_F0F0_F0F0, 32'hFFFF_FFFF, 1'b1, ST_DONE,      1'b0},
    '{OP_GRANT,  64'h0000_0001_0000_0000, 32'h0001_0000, 1'b1, ST_DONE,      1'b0},
    '{OP_GRANT,  64'h0000_0000_0000_0003, 32'h0000_0003, 1'b1, ST_DONE,      1'b0},
    // table is full now
    '{OP_GRANT,  64'h0000_0000_0000_0002, 32'h0000_0001, 1'b1, ST_FULL,      1'b0},
    '{OP_CHECK,  64'h0000_0000_0000_0002, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 1'b0},
    '{OP_GRANT,  64'hFFFF_FFFF_FFFF_FFFF, 32'h5555_5555, 1'b0, ST_DONE,      1'b0},
    '{OP_CHECK,  64'hFFFF_FFFF_FFFF_FFFE, 32'h5555_0000, 1'b0, ST_DONE,      1'b0}
  };

  logic        clk;
  logic        rst;
  logic        start;
  req_op_t     req_type;
  logic [63:0] principal_key;
  logic [31:0] rights_mask;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic        permitted;

  // behavioral copy of the table
  logic [63:0] tbl_keys  [MAX_ENTRIES];
  logic [31:0] tbl_allow [MAX_ENTRIES];
  logic [31:0] tbl_deny  [MAX_ENTRIES];
  int          tbl_used;

  rights_result_t pending_results [$];
  int             mismatch_count = 0;
  int             cycle_count = 0;

  access_rights_table u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .req_type      (req_type),
    .principal_key (principal_key),
    .rights_mask   (rights_mask),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .permitted     (permitted)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic rights_result_t apply_request(req_op_t op, logic [63:0] key_in,
                                                   logic [31:0] mask_in);
    logic [63:0]    key;
    logic [31:0]    rights;
    int             hit;
    rights_result_t res;
    key    = key_in & KEY_KEEP;
    rights = mask_in & RIGHTS_KEEP;
    hit    = -1;
    for (int i = 0; i < tbl_used; i++) begin
      if (hit < 0 && tbl_keys[i] == key) hit = i;
    end
    res.status    = ST_DONE;
    res.permitted = 1'b0;
    case (op)
      OP_GRANT: begin
        if (hit >= 0) begin
          tbl_allow[hit] = tbl_allow[hit] | rights;
        end else if (tbl_used < MAX_ENTRIES) begin
          tbl_keys[tbl_used]  = key;
          tbl_allow[tbl_used] = rights;
          tbl_deny[tbl_used]  = '0;
          tbl_used++;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_DENY: begin
        if (hit >= 0) tbl_deny[hit] = tbl_deny[hit] | rights;
        else res.status = ST_NOT_FOUND;
      end
      OP_REVOKE: begin
        if (hit >= 0) tbl_allow[hit] = tbl_allow[hit] & ~rights;
        else res.status = ST_NOT_FOUND;
      end
      default: begin
        if (hit >= 0)
          res.permitted = ((tbl_allow[hit] & rights) == rights) &&
                          ((tbl_deny[hit] & rights) == '0);
        else
          res.status = ST_NOT_FOUND;
      end
    endcase
    return res;
  endfunction

  int idle_max;

  // start stays high across back-to-back words; lowered only for a real gap
  task automatic send_request(req_op_t op, logic [63:0] key, logic [31:0] mask,
                              logic known, rights_result_t known_res);
    int             gap;
    rights_result_t res;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    req_type      <= op;
    principal_key <= key;
    rights_mask   <= mask;
    do @(posedge clk); while (busy);
    res = apply_request(op, key, mask);
    pending_results.push_back(known ? known_res : res);
  endtask

  always @(posedge clk) begin
    rights_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: status %0d permitted %0d",
               status, permitted);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          mismatch_count++;
        end
        if (permitted !== want.permitted) begin
          $error("permitted: expected %0d, actual %0d", want.permitted, permitted);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    req_op_t        op;
    logic [63:0]    key;
    logic [31:0]    mask;
    rights_result_t row_res;
    int             entry;
    int             pick;
    tbl_used       = 0;
    idle_max       = 4;
    rst            = 1'b1;
    start          = 1'b0;
    req_type       = OP_GRANT;
    principal_key  = '0;
    rights_mask    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row_res.status    = DIRECTED[i].status;
      row_res.permitted = DIRECTED[i].permitted;
      send_request(DIRECTED[i].op, DIRECTED[i].key, DIRECTED[i].mask,
                   DIRECTED[i].known, row_res);
    end

    row_res = '0;
    for (int n = 0; n < N_RANDOM; n++) begin
      // now and then a stretch of back-to-back words
      if (n % 64 == 0) idle_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      op    = req_op_t'($urandom_range(0, 3));
      entry = $urandom_range(0, tbl_used - 1);
      pick  = $urandom_range(0, 9);
      if (pick < 7)
        key = tbl_keys[entry];
      else if (pick < 9)
        key = {$urandom, $urandom};
      else
        key = tbl_keys[entry] ^ (64'd1 << $urandom_range(0, 63)); // near miss
      case ($urandom_range(0, 9))
        0:       mask = '0;
        1:       mask = '1;
        2, 3, 4: mask = $urandom;
        5, 6:    mask = $urandom & $urandom & $urandom;
        default: mask = tbl_allow[entry] & ~tbl_deny[entry] & $urandom;
      endcase
      send_request(op, key, mask, 1'b0, row_res);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
src/art_pkg.sv
src/art_ram.sv
src/access_rights_table.sv
bench/access_rights_table_tb.sv
